// File: rtl/bss_pkg.sv
// Shared types and constants for the bit stack store.
package bss_pkg;

    localparam int CAPACITY_BITS  = 1024;
    localparam int MAX_CHUNK_BITS = 31;
    localparam int STORE_BYTES    = (CAPACITY_BITS + 7) / 8;
    localparam int BYTE_AW        = $clog2(STORE_BYTES);
    localparam int BYTE_CW        = $clog2(STORE_BYTES + 1);
    localparam int LEN_W          = $clog2(CAPACITY_BITS + 1);
    localparam int POS_W          = $clog2(CAPACITY_BITS);
    localparam int SPOS_W         = LEN_W + 1;
    localparam int IDX_W          = 11;
    localparam int CNT_W          = 5;
    localparam int WORD_W         = 31;
    localparam int REQ_W          = 3;
    localparam int STATUS_W       = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_TEST   = 3'd0,
        REQ_ASSIGN = 3'd1,
        REQ_TOGGLE = 3'd2,
        REQ_PUSH   = 3'd3,
        REQ_POP    = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_CAPACITY  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_STEP,
        S_WRITE,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        BIT_KEEP,
        BIT_WRITE,
        BIT_FLIP
    } bit_op_t;

    typedef struct packed {
        logic [BYTE_AW-1:0] rd_addr;
        logic               wr_en;
        logic [BYTE_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
        logic               clr_en;
        logic [BYTE_CW-1:0] clr_lo;
        logic [BYTE_CW-1:0] clr_hi;
    } store_req_t;

endpackage

// File: rtl/bss_bit_unit.sv
// Shared bit unit: selects one bit of a byte and writes, keeps or flips it.
module bss_bit_unit (
    input  logic [7:0]      byte_in,
    input  logic [2:0]      bit_sel,
    input  bss_pkg::bit_op_t mode,
    input  logic            wr_val,
    output logic            bit_rd,
    output logic            bit_new,
    output logic [7:0]      byte_out
);
    import bss_pkg::*;

    // Select the bit, form its new value and merge it back
    always_comb
    begin
        bit_rd = byte_in[bit_sel];
        unique case (mode)
            BIT_KEEP:  bit_new = bit_rd;
            BIT_WRITE: bit_new = wr_val;
            BIT_FLIP:  bit_new = ~bit_rd;
            default:   bit_new = bit_rd;
        endcase
        byte_out          = byte_in;
        byte_out[bit_sel] = bit_new;
    end

endmodule

// File: rtl/bss_store.sv
// Byte memory with per-byte valid flags; an invalid byte reads as zero.
module bss_store (
    input  logic                clk,
    input  logic                rst_n,
    input  bss_pkg::store_req_t req,
    output logic [7:0]          rd_byte
);
    import bss_pkg::*;

    logic [7:0]             mem [STORE_BYTES];
    logic [7:0]             rd_data_reg;
    logic                   rd_valid_reg;
    logic [STORE_BYTES-1:0] valid_reg;
    logic [STORE_BYTES-1:0] valid_next;

    // Write one byte and read one byte per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    // Drop valid flags of bytes uncovered by growth, mark written bytes
    always_comb
    begin
        valid_next = valid_reg;
        for (int b = 0; b < STORE_BYTES; b++)
        begin
            if (req.clr_en && (BYTE_CW'(b) >= req.clr_lo) && (BYTE_CW'(b) < req.clr_hi))
            begin
                valid_next[b] = 1'b0;
            end
        end
        if (req.wr_en)
        begin
            valid_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    assign rd_byte = rd_valid_reg ? rd_data_reg : 8'd0;

endmodule

// File: rtl/bit_stack_store.sv
// Top level: request decode and bit sequencer of the bit stack store.
// A rejected or empty request goes straight to S_FINISH; otherwise each byte that the
// request spans is read through S_FETCH and S_LOAD, takes one S_STEP per bit and, for a
// writing request, S_WRITE: one byte memory port, one bit per step, up to 5 bytes per chunk.
// Throughput: one transaction at a time; the next is taken once the result is
// registered. Reset clears the length and all byte valid flags at once.
module bit_stack_store (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [bss_pkg::REQ_W-1:0]          req_type,
    input  logic signed [bss_pkg::IDX_W-1:0]   bit_index,
    input  logic                               bit_in,
    input  logic [bss_pkg::WORD_W-1:0]         push_word,
    input  logic [bss_pkg::CNT_W-1:0]          bit_count,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic                               bit_out,
    output logic [bss_pkg::WORD_W-1:0]         pop_word,
    output logic [bss_pkg::LEN_W-1:0]          length_now,
    output logic [bss_pkg::STATUS_W-1:0]       status
);
    import bss_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHUNK_BITS);

    state_t             state_reg,   state_next;
    logic [LEN_W-1:0]   len_reg,     len_next;
    logic [POS_W-1:0]   pos_reg,     pos_next;
    logic [CNT_W-1:0]   rem_reg,     rem_next;
    req_t               op_reg,      op_next;
    logic               val_reg,     val_next;
    logic [WORD_W-1:0]  word_reg,    word_next;
    logic [7:0]         work_reg,    work_next;
    logic [BYTE_AW-1:0] addr_reg,    addr_next;
    logic               bit_reg,     bit_next;
    status_t            status_reg,  status_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               out_bit_reg, out_bit_next;
    logic [WORD_W-1:0]  out_word_reg, out_word_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;
    status_t            out_status_reg, out_status_next;

    logic signed [SPOS_W-1:0] idx_s;
    logic signed [SPOS_W-1:0] len_s;
    logic signed [SPOS_W-1:0] pos_s;
    logic                     pos_neg;
    logic [LEN_W-1:0]         pos_u;
    logic [CNT_W-1:0]         cnt_sat;
    logic [LEN_W:0]           push_sum;
    logic [LEN_W:0]           grow_len;
    logic [LEN_W:0]           old_p7;
    logic [LEN_W:0]           new_p7;
    logic [LEN_W-1:0]         len_m1;

    store_req_t         st_req;
    logic [7:0]         rd_byte;
    bit_op_t            bu_mode;
    logic               bu_wr_val;
    logic               bu_bit_rd;
    logic               bu_bit_new;
    logic [7:0]         bu_byte;
    logic               op_writes;
    logic               last_bit;
    logic               byte_end;
    logic               go;

    bss_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (st_req),
        .rd_byte (rd_byte)
    );

    bss_bit_unit u_bit_unit (
        .byte_in  (work_reg),
        .bit_sel  (pos_reg[2:0]),
        .mode     (bu_mode),
        .wr_val   (bu_wr_val),
        .bit_rd   (bu_bit_rd),
        .bit_new  (bu_bit_new),
        .byte_out (bu_byte)
    );

    // Wrap the index and size the growth of the incoming request
    always_comb
    begin
        idx_s    = {{(SPOS_W - IDX_W){bit_index[IDX_W-1]}}, bit_index};
        len_s    = signed'({1'b0, len_reg});
        pos_s    = bit_index[IDX_W-1] ? idx_s + len_s : idx_s;
        pos_neg  = pos_s[SPOS_W-1];
        pos_u    = pos_s[LEN_W-1:0];
        cnt_sat  = (bit_count > CNT_MAX) ? CNT_MAX : bit_count;
        push_sum = {1'b0, len_reg} + (LEN_W + 1)'(cnt_sat);
        grow_len = (req_t'(req_type) == REQ_PUSH) ? push_sum
                                                   : {1'b0, pos_u} + (LEN_W + 1)'(1);
        old_p7   = {1'b0, len_reg} + (LEN_W + 1)'(7);
        new_p7   = grow_len + (LEN_W + 1)'(7);
        len_m1   = len_reg - LEN_W'(1);
    end

    // Per-bit controls for the shared bit unit
    always_comb
    begin
        op_writes = (op_reg == REQ_ASSIGN) || (op_reg == REQ_TOGGLE) || (op_reg == REQ_PUSH);
        last_bit  = (rem_reg == CNT_W'(1));
        byte_end  = (op_reg == REQ_POP) ? (pos_reg[2:0] == 3'd0) : (pos_reg[2:0] == 3'd7);
        bu_wr_val = 1'b0;
        case (op_reg)
            REQ_ASSIGN:
            begin
                bu_mode   = BIT_WRITE;
                bu_wr_val = val_reg;
            end
            REQ_PUSH:
            begin
                bu_mode   = BIT_WRITE;
                bu_wr_val = word_reg[0];
            end
            REQ_TOGGLE: bu_mode = BIT_FLIP;
            default:    bu_mode = BIT_KEEP;
        endcase
    end

    // Next state, datapath updates and store requests
    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        word_next       = word_reg;
        work_next       = work_reg;
        addr_next       = addr_reg;
        bit_next        = bit_reg;
        status_next     = status_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        out_bit_next    = out_bit_reg;
        out_word_next   = out_word_reg;
        out_len_next    = out_len_reg;
        out_status_next = out_status_reg;
        go              = 1'b0;

        st_req.rd_addr  = pos_reg[POS_W-1:3];
        st_req.wr_en    = 1'b0;
        st_req.wr_addr  = addr_reg;
        st_req.wr_data  = work_reg;
        st_req.clr_en   = 1'b0;
        st_req.clr_lo   = BYTE_CW'(old_p7 >> 3);
        st_req.clr_hi   = BYTE_CW'(new_p7 >> 3);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req_t'(req_type);
                    val_next    = bit_in;
                    word_next   = '0;
                    bit_next    = 1'b0;
                    status_next = ST_OK;
                    rem_next    = CNT_W'(1);
                    pos_next    = pos_u[POS_W-1:0];
                    case (req_t'(req_type)) inside
                        REQ_TEST, REQ_TOGGLE:
                        begin
                            if (pos_neg || (pos_u >= len_reg))
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                go = 1'b1;
                            end
                        end
                        REQ_ASSIGN:
                        begin
                            if (pos_neg)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (pos_u >= LEN_W'(CAPACITY_BITS))
                            begin
                                status_next = ST_CAPACITY;
                            end
                            else
                            begin
                                if (pos_u >= len_reg)
                                begin
                                    st_req.clr_en = 1'b1;
                                    len_next      = grow_len[LEN_W-1:0];
                                end
                                go = 1'b1;
                            end
                        end
                        REQ_PUSH:
                        begin
                            if (push_sum > (LEN_W + 1)'(CAPACITY_BITS))
                            begin
                                status_next = ST_CAPACITY;
                            end
                            else
                            begin
                                st_req.clr_en = 1'b1;
                                len_next      = push_sum[LEN_W-1:0];
                                rem_next      = cnt_sat;
                                pos_next      = len_reg[POS_W-1:0];
                                word_next     = push_word;
                                go            = (cnt_sat != '0);
                            end
                        end
                        REQ_POP:
                        begin
                            if (LEN_W'(cnt_sat) > len_reg)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                len_next = len_reg - LEN_W'(cnt_sat);
                                rem_next = cnt_sat;
                                pos_next = len_m1[POS_W-1:0];
                                go       = (cnt_sat != '0);
                            end
                        end
                        default:
                        begin
                            go = 1'b0;
                        end
                    endcase
                    state_next = go ? S_FETCH : S_FINISH;
                end
            end
            S_FETCH:
            begin
                addr_next  = pos_reg[POS_W-1:3];
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                work_next  = rd_byte;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                work_next = bu_byte;
                rem_next  = rem_reg - CNT_W'(1);
                if (op_reg == REQ_POP)
                begin
                    pos_next  = pos_reg - POS_W'(1);
                    word_next = {word_reg[WORD_W-2:0], bu_bit_rd};
                end
                else
                begin
                    pos_next  = pos_reg + POS_W'(1);
                    word_next = word_reg >> 1;
                end
                if ((op_reg == REQ_TEST) || (op_reg == REQ_TOGGLE))
                begin
                    bit_next = bu_bit_new;
                end
                if (last_bit || byte_end)
                begin
                    if (op_writes)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = last_bit ? S_FINISH : S_FETCH;
                    end
                end
            end
            S_WRITE:
            begin
                st_req.wr_en = 1'b1;
                state_next   = (rem_reg == '0) ? S_FINISH : S_FETCH;
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    out_bit_next    = bit_reg;
                    out_word_next   = (op_reg == REQ_POP) ? word_reg : '0;
                    out_len_next    = len_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Advance datapath and result registers
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        rem_reg        <= rem_next;
        op_reg         <= op_next;
        val_reg        <= val_next;
        word_reg       <= word_next;
        work_reg       <= work_next;
        addr_reg       <= addr_next;
        bit_reg        <= bit_next;
        status_reg     <= status_next;
        out_bit_reg    <= out_bit_next;
        out_word_reg   <= out_word_next;
        out_len_reg    <= out_len_next;
        out_status_reg <= out_status_next;
    end

    assign req_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign bit_out    = out_bit_reg;
    assign pop_word   = out_word_reg;
    assign length_now = out_len_reg;
    assign status     = out_status_reg;

endmodule

// File: dv/bss_tb_pkg.sv
// Result type and shadow model of the bit stack store, used by the testbench.
package bss_tb_pkg;

    import bss_pkg::*;

    // First request code that the block ignores
    localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = REQ_POP + REQ_W'(1);

    typedef struct packed {
        logic                bit_out;
        logic [WORD_W-1:0]   pop_word;
        logic [LEN_W-1:0]    length_now;
        status_t             status;
    } bss_result_t;

    class bit_stack_shadow;

        logic [7:0]   shadow_bytes [STORE_BYTES];
        int unsigned  len;
        bss_result_t  pending_results [$];
        int unsigned  errors;
        int unsigned  requests;
        int unsigned  unknown_seen;
        int unsigned  peak_len;
        int unsigned  status_seen [4];

        function new();
            foreach (shadow_bytes[b])
                shadow_bytes[b] = '0;
            foreach (status_seen[s])
                status_seen[s] = 0;
            len = 0;
            errors = 0;
            requests = 0;
            unknown_seen = 0;
            peak_len = 0;
        endfunction

        function logic read_bit(int unsigned p);
            return shadow_bytes[(p >> 3) % STORE_BYTES][p & 7];
        endfunction

        function void write_bit(int unsigned p, logic v);
            shadow_bytes[(p >> 3) % STORE_BYTES][p & 7] = v;
        endfunction

        // Clear whole bytes newly covered by the length, keep partial-byte leftovers
        function void grow_to(int unsigned new_len);
            int unsigned old_b;
            int unsigned new_b;
            old_b = (len + 7) >> 3;
            new_b = (new_len + 7) >> 3;
            for (int unsigned b = old_b; b < new_b && b < STORE_BYTES; b++)
                shadow_bytes[b] = '0;
            len = new_len;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        // Apply one accepted transaction and queue the result it should give
        function void note_request(logic [REQ_W-1:0] req, logic signed [IDX_W-1:0] idx,
                                   logic bin, logic [WORD_W-1:0] word,
                                   logic [CNT_W-1:0] cnt);
            bss_result_t  r;
            int           pos;
            int unsigned  n;
            int unsigned  base;
            r = '0;
            r.status = ST_OK;
            n = cnt;
            if (n > MAX_CHUNK_BITS)
                n = MAX_CHUNK_BITS;
            pos = (idx < 0) ? int'(idx) + int'(len) : int'(idx);

            case (req) inside
                REQ_TEST, REQ_TOGGLE:
                begin
                    if (pos < 0 || pos >= int'(len))
                        r.status = ST_RANGE;
                    else if (req == REQ_TEST)
                        r.bit_out = read_bit(pos);
                    else
                    begin
                        r.bit_out = ~read_bit(pos);
                        write_bit(pos, r.bit_out);
                    end
                end
                REQ_ASSIGN:
                begin
                    if (pos < 0)
                        r.status = ST_RANGE;
                    else if (pos + 1 > CAPACITY_BITS)
                        r.status = ST_CAPACITY;
                    else
                    begin
                        if (pos >= int'(len))
                            grow_to(pos + 1);
                        write_bit(pos, bin);
                    end
                end
                REQ_PUSH:
                begin
                    if (len + n > CAPACITY_BITS)
                        r.status = ST_CAPACITY;
                    else
                    begin
                        base = len;
                        grow_to(len + n);
                        for (int unsigned i = 0; i < n; i++)
                            write_bit(base + i, word[i]);
                    end
                end
                REQ_POP:
                begin
                    if (n > len)
                        r.status = ST_UNDERFLOW;
                    else
                    begin
                        for (int unsigned i = 0; i < n; i++)
                        begin
                            r.pop_word = {r.pop_word[WORD_W-2:0], read_bit(len - 1)};
                            len--;
                        end
                    end
                end
                default:
                    unknown_seen++;
            endcase

            r.length_now = LEN_W'(len);
            pending_results.push_back(r);
            requests++;
            status_seen[r.status]++;
            if (len > peak_len)
                peak_len = len;
        endfunction

        // Compare one accepted result with the oldest queued one
        function void check_response(logic bout, logic [WORD_W-1:0] pword,
                                     logic [LEN_W-1:0] lnow, logic [STATUS_W-1:0] st);
            bss_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("result arrived with no transaction outstanding");
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (bout !== e.bit_out)
            begin
                $error("bit_out mismatch: expected %0d, actual %0d", e.bit_out, bout);
                errors++;
            end
            if (pword !== e.pop_word)
            begin
                $error("pop_word mismatch: expected 0x%08h, actual 0x%08h", e.pop_word, pword);
                errors++;
            end
            if (lnow !== e.length_now)
            begin
                $error("length_now mismatch: expected %0d, actual %0d", e.length_now, lnow);
                errors++;
            end
            if (st !== e.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", e.status, st);
                errors++;
            end
        endfunction

    endclass

endpackage

// File: dv/testbench.sv
// Top-level testbench of the bit stack store: stimulus, response stalls and checking.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import bss_pkg::*;
    import bss_tb_pkg::*;

    localparam int RANDOM_REQUESTS  = 1950;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int HOLD_AT          = 600;
    localparam int PAUSE_AT         = 1200;
    localparam int DRAIN_CYCLES     = 100;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY
    } stall_mode_t;

    logic                        clk;
    logic                        rst_n;
    logic                        req_valid;
    logic                        req_stall;
    logic [REQ_W-1:0]            req_type;
    logic signed [IDX_W-1:0]     bit_index;
    logic                        bit_in;
    logic [WORD_W-1:0]           push_word;
    logic [CNT_W-1:0]            bit_count;
    logic                        rsp_valid;
    logic                        rsp_stall;
    logic                        bit_out;
    logic [WORD_W-1:0]           pop_word;
    logic [LEN_W-1:0]            length_now;
    logic [STATUS_W-1:0]         status;

    bit_stack_shadow  sb;
    int unsigned      burst_left;
    bit               filling;
    bit               long_hold_due;

    bit_stack_store u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .bit_index  (bit_index),
        .bit_in     (bit_in),
        .push_word  (push_word),
        .bit_count  (bit_count),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .bit_out    (bit_out),
        .pop_word   (pop_word),
        .length_now (length_now),
        .status     (status)
    );

    // Generate the 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Record accepted requests and check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req_type, bit_index, bit_in, push_word, bit_count);
            if (rsp_valid && !rsp_stall)
                sb.check_response(bit_out, pop_word, length_now, status);
        end
    end

    // Stall the result side in patterns, with one long hold-off on request
    initial
    begin
        stall_mode_t  mode;
        int unsigned  mode_left;
        bit           hold_done;
        mode = STALL_NONE;
        mode_left = 0;
        hold_done = 1'b0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_due && !hold_done)
            begin
                hold_done = 1'b1;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = stall_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  rsp_stall <= 1'b0;
                    STALL_LIGHT: rsp_stall <= ($urandom_range(0, 4) == 0);
                    default:     rsp_stall <= ($urandom_range(0, 2) != 0);
                endcase
            end
        end
    end

    // Advance to the next falling edge, idling between bursts
    task automatic wait_slot();
        int unsigned gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    // Present one transaction and hold it until accepted
    task automatic drive_request(logic [REQ_W-1:0] req, logic signed [IDX_W-1:0] idx,
                                 logic bin, logic [WORD_W-1:0] word, logic [CNT_W-1:0] cnt);
        req_valid <= 1'b1;
        req_type  <= req;
        bit_index <= idx;
        bit_in    <= bin;
        push_word <= word;
        bit_count <= cnt;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic send(logic [REQ_W-1:0] req, int idx, logic bin,
                        logic [WORD_W-1:0] word, int cnt);
        wait_slot();
        drive_request(req, IDX_W'(idx), bin, word, CNT_W'(cnt));
    endtask

    // Choose a random transaction, steering the length between empty and full
    task automatic pick_request(output logic [REQ_W-1:0] req,
                                output logic signed [IDX_W-1:0] idx,
                                output logic bin, output logic [WORD_W-1:0] word,
                                output logic [CNT_W-1:0] cnt);
        int           l;
        int unsigned  sel;
        int unsigned  p_push;
        int unsigned  p_pop;
        int unsigned  k;
        int           grown;
        l = int'(sb.len);
        if (l > 1000)
            filling = 1'b0;
        else if (l < 24)
            filling = 1'b1;
        else if ($urandom_range(0, 79) == 0)
            filling = ~filling;
        p_push = filling ? 34 : 12;
        p_pop  = filling ? 12 : 34;
        sel  = $urandom_range(0, 99);
        req  = REQ_TEST;
        idx  = IDX_W'($urandom());
        bin  = 1'($urandom());
        word = WORD_W'($urandom());
        cnt  = CNT_W'($urandom());

        if (sel < p_push)
        begin
            req = REQ_PUSH;
            // aim at the exact capacity boundary now and then
            if (CAPACITY_BITS - l < MAX_CHUNK_BITS && $urandom_range(0, 2) == 0)
                cnt = CNT_W'(CAPACITY_BITS - l + int'($urandom_range(0, 1)));
        end
        else if (sel < p_push + p_pop)
        begin
            req = REQ_POP;
            // aim at the underflow boundary when nearly empty
            if (l < MAX_CHUNK_BITS && $urandom_range(0, 2) == 0)
                cnt = CNT_W'(l + int'($urandom_range(0, 1)));
        end
        else if (sel < 90)
        begin
            case (sel % 3)
                0:       req = REQ_TEST;
                1:       req = REQ_TOGGLE;
                default: req = REQ_ASSIGN;
            endcase
            k = $urandom_range(0, 9);
            if (l > 0 && k < 6)
                idx = IDX_W'($urandom_range(0, l - 1));
            else if (l > 0 && k < 8)
                idx = IDX_W'(-int'($urandom_range(1, l)));
            else if (req == REQ_ASSIGN && $urandom_range(0, 1) == 0)
            begin
                grown = l + int'($urandom_range(0, 40));
                idx = IDX_W'((grown > CAPACITY_BITS - 1) ? CAPACITY_BITS - 1 : grown);
            end
        end
        else if (sel < 94)
            req = REQ_FIRST_UNUSED + REQ_W'($urandom_range(0, 2));
        else
            req = REQ_W'($urandom_range(0, 7));
    endtask

    // Stop a run that hangs
    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    // Reset, directed cases, random traffic, drain and report
    initial
    begin
        logic [REQ_W-1:0]         r_req;
        logic signed [IDX_W-1:0]  r_idx;
        logic                     r_bin;
        logic [WORD_W-1:0]        r_word;
        logic [CNT_W-1:0]         r_cnt;
        sb = new();
        burst_left = 0;
        filling = 1'b1;
        long_hold_due = 1'b0;
        req_valid = 1'b0;
        req_type  = REQ_TEST;
        bit_index = '0;
        bit_in    = 1'b0;
        push_word = '0;
        bit_count = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty store: range and underflow, zero-length push and pop
        send(REQ_TEST,   0,     1'b0, 31'h0,        0);
        send(REQ_POP,    0,     1'b0, 31'h0,        1);
        send(REQ_PUSH,   0,     1'b0, 31'h7FFFFFFF, 0);
        send(REQ_POP,    0,     1'b0, 31'h0,        0);
        // fill two full chunks, probe both ends
        send(REQ_PUSH,   0,     1'b0, 31'h7FFFFFFF, 31);
        send(REQ_PUSH,   0,     1'b0, 31'h2AAAAAAA, 31);
        send(REQ_TEST,   0,     1'b0, 31'h0,        0);
        send(REQ_TEST,   -1,    1'b0, 31'h0,        0);
        send(REQ_TOGGLE, 5,     1'b0, 31'h0,        0);
        send(REQ_TOGGLE, -1024, 1'b0, 31'h0,        0);
        // assign past the end grows with cleared bytes
        send(REQ_ASSIGN, 100,   1'b1, 31'h0,        0);
        send(REQ_TEST,   99,    1'b0, 31'h0,        0);
        send(REQ_ASSIGN, -1,    1'b0, 31'h0,        0);
        // shrink then regrow inside the same byte: leftover bits stay
        send(REQ_POP,    0,     1'b0, 31'h0,        3);
        send(REQ_ASSIGN, 103,   1'b1, 31'h0,        0);
        send(REQ_TEST,   100,   1'b0, 31'h0,        0);
        send(REQ_TEST,   1023,  1'b0, 31'h0,        0);
        // grow to full capacity, then overflow
        send(REQ_ASSIGN, 1023,  1'b1, 31'h0,        0);
        send(REQ_PUSH,   0,     1'b1, 31'h1,        1);
        send(REQ_TEST,   -1,    1'b0, 31'h0,        0);
        send(REQ_POP,    0,     1'b0, 31'h0,        31);
        // ignored request codes
        send(REQ_FIRST_UNUSED,              -1,   1'b1, 31'h7FFFFFFF, 31);
        send(REQ_FIRST_UNUSED + REQ_W'(1),  7,    1'b0, 31'h12345678, 5);
        send(REQ_FIRST_UNUSED + REQ_W'(2),  -512, 1'b1, 31'h0,        17);
        send(REQ_ASSIGN, -1024, 1'b1, 31'h0,        0);
        send(REQ_PUSH,   0,     1'b0, 31'h5A5A5A5A, 31);

        // random traffic
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == HOLD_AT)
                long_hold_due = 1'b1;
            if (n == PAUSE_AT)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                while (sb.pending() != 0)
                    @(negedge clk);
            end
            wait_slot();
            pick_request(r_req, r_idx, r_bin, r_word, r_cnt);
            drive_request(r_req, r_idx, r_bin, r_word, r_cnt);
        end

        // drop valid and drain outstanding results
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d transactions: %0d ok, %0d out of range, %0d over capacity, %0d underflow",
                 sb.requests, sb.status_seen[ST_OK], sb.status_seen[ST_RANGE],
                 sb.status_seen[ST_CAPACITY], sb.status_seen[ST_UNDERFLOW]);
        $display("Ignored codes seen %0d times, peak length %0d bits, %0d mismatches",
                 sb.unknown_seen, sb.peak_len, sb.errors);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: bit_stack_store.f
rtl/bss_pkg.sv
rtl/bss_bit_unit.sv
rtl/bss_store.sv
rtl/bit_stack_store.sv
dv/bss_tb_pkg.sv
dv/testbench.sv
